@@ design/assert_macros.svh @@
// assertion helpers used by the top-level allocator module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define VPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VPA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define VPA_ASSERT(label, prop, msg)
`define VPA_NEVER(label, cond, msg)
`endif

`endif

@@ design/vpa_pkg.sv @@
package vpa_pkg;

	localparam int OWNER_W = 8;
	localparam int SIZE_W = 16;
	localparam int unsigned POOL_RESET = 640;

	localparam logic REG_FIT = 1'b0;
	localparam logic REG_POOL = 1'b1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT = 2'd3
	} fit_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NOOWNER = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic fscan_pick;
		logic fscan_nbr;
		logic nf_retry;
		logic uscan;
		logic acommit;
		logic fcommit;
		logic fail;
		status_t fail_code;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic size_zero;
		logic tbl_full;
		logic ucnt_zero;
		logic nf_mode;
		logic fdone;
		logic pk_found;
		logic udone;
		logic ufound;
		logic merge_ok;
		logic shdone;
		logic out_busy;
	} stat_t;

endpackage

@@ design/vpa_ctrl.sv @@
module vpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	input  vpa_pkg::stat_t st,
	output vpa_pkg::cmd_t  cmd
);
	import vpa_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_DECIDE  = 9'b000000010,
		S_ASCAN   = 9'b000000100,
		S_ACOMMIT = 9'b000001000,
		S_USCAN   = 9'b000010000,
		S_FSCAN   = 9'b000100000,
		S_FAPPLY  = 9'b001000000,
		S_SHIFT   = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic retry_q, retry_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		retry_d = retry_q;
		cmd = '0;
		cmd.fail_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					retry_d = 1'b0;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!st.op_free) begin
					if (st.size_zero) begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_NOFIT;
						state_d = S_DONE;
					end else if (st.tbl_full) begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.fscan_pick = 1'b1;
						state_d = S_ASCAN;
					end
				end else if (st.ucnt_zero) begin
					cmd.fail = 1'b1;
					cmd.fail_code = ST_NOOWNER;
					state_d = S_DONE;
				end else begin
					cmd.uscan = 1'b1;
					state_d = S_USCAN;
				end
			end
			S_ASCAN: begin
				if (st.fdone) begin
					if (st.pk_found) begin
						state_d = S_ACOMMIT;
					end else if (st.nf_mode && !retry_q) begin
						cmd.nf_retry = 1'b1;
						retry_d = 1'b1;
					end else begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_NOFIT;
						state_d = S_DONE;
					end
				end
			end
			S_ACOMMIT: begin
				cmd.acommit = 1'b1;
				state_d = S_DONE;
			end
			S_USCAN: begin
				if (st.udone) begin
					if (st.ufound) begin
						cmd.fscan_nbr = 1'b1;
						state_d = S_FSCAN;
					end else begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_NOOWNER;
						state_d = S_DONE;
					end
				end
			end
			S_FSCAN: begin
				if (st.fdone) begin
					if (st.merge_ok) begin
						state_d = S_FAPPLY;
					end else begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_FULL;
						state_d = S_DONE;
					end
				end
			end
			S_FAPPLY: begin
				cmd.fcommit = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (st.shdone) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			retry_q <= 1'b0;
		end else begin
			state_q <= state_d;
			retry_q <= retry_d;
		end
	end

endmodule

@@ design/vpa_dpath.sv @@
module vpa_dpath #(
	parameter int NF = 64,
	parameter int NA = 64,
	parameter int AW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [vpa_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          op,
	input  logic [vpa_pkg::OWNER_W-1:0]   owner_id,
	input  logic [vpa_pkg::SIZE_W-1:0]    request_size,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [vpa_pkg::SIZE_W-1:0]    block_start,
	output logic [vpa_pkg::SIZE_W-1:0]    block_length,
	input  vpa_pkg::cmd_t                 cmd,
	output vpa_pkg::stat_t                st
);
	import vpa_pkg::*;

	localparam int CW = (AW > SIZE_W) ? AW : SIZE_W;
	localparam int FIW = $clog2(NF);
	localparam int UIW = (NA > 1) ? $clog2(NA) : 1;
	localparam int CNW = $clog2(NA + 1);
	localparam int UDW = OWNER_W + 2 * AW;
	localparam logic [CW-1:0] AMASK = CW'({AW{1'b1}});
	localparam logic [CW-1:0] POOL_INIT =
		(CW'(POOL_RESET) > AMASK) ? AMASK : CW'(POOL_RESET);

	// request and configuration
	logic                op_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SIZE_W-1:0]   size_q;
	fit_t                fit_q;
	logic [AW-1:0]       units_q;
	logic [AW-1:0]       nf_q;
	logic [NF-1:0]       fvld_q;
	logic                e0_ovr_q;
	logic [CNW-1:0]      ucnt_q;

	// tables
	logic [2*AW-1:0]     fmem [NF];
	logic [UDW-1:0]      umem [NA];
	logic [2*AW-1:0]     frd_q;
	logic [UDW-1:0]      urd_q;

	// free table scan
	logic                f_run_q;
	logic [FIW-1:0]      fa_q;
	logic                fv_s1;
	logic [FIW-1:0]      fidx_s1;
	logic                fov_s1;
	logic                nbr_q;
	fit_t                rule_q;
	logic [AW-1:0]       low_q;
	logic                fdone_q;

	logic                pk_found_q;
	logic [FIW-1:0]      pk_idx_q;
	logic [AW-1:0]       pk_st_q, pk_len_q;
	logic                lf_q, rf_q, sf_q;
	logic [FIW-1:0]      l_idx_q, r_idx_q, s_idx_q;
	logic [AW-1:0]       l_st_q, l_len_q, r_len_q;

	// used table scan and compaction
	logic                u_run_q;
	logic                u_act_q;
	logic [UIW-1:0]      ua_q;
	logic                uv_s1;
	logic [UIW-1:0]      uidx_s1;
	logic                ufound_q, udone_q;
	logic [UIW-1:0]      u_idx_q;
	logic [AW-1:0]       us_q, ul_q;
	logic                sh_run_q;
	logic [UIW-1:0]      sa_q;
	logic                shv_s1;
	logic [UIW-1:0]      swa_s1;
	logic                shdone_q;

	// result
	status_t             res_st_q, out_st_q;
	logic [SIZE_W-1:0]   res_start_q, res_len_q, out_start_q, out_len_q;
	logic                out_valid_q;

	logic [AW-1:0]       e_st, e_len;
	logic                e_vld, cand, better, end_lo, end_hi;
	logic [AW-1:0]       sz_a;
	logic [CW-1:0]       pool_v, units_v;
	logic                fw_en;
	logic [FIW-1:0]      fw_addr;
	logic [2*AW-1:0]     fw_data;
	logic [UIW-1:0]      uaddr;
	logic                umatch, ulast;

	assign e_st  = fov_s1 ? '0 : frd_q[2*AW-1:AW];
	assign e_len = fov_s1 ? units_q : frd_q[AW-1:0];
	assign e_vld = fvld_q[fidx_s1];
	assign sz_a  = AW'(size_q);

	assign cand = e_vld && (CW'(e_len) >= CW'(size_q)) && (e_st >= low_q);
	always_comb begin
		case (rule_q)
			FIT_BEST:  better = (e_len < pk_len_q) || (e_len == pk_len_q && e_st < pk_st_q);
			FIT_WORST: better = (e_len > pk_len_q) || (e_len == pk_len_q && e_st < pk_st_q);
			default:   better = e_st < pk_st_q;
		endcase
	end
	assign end_lo = ({1'b0, e_st} + {1'b0, e_len}) == {1'b0, us_q};
	assign end_hi = ({1'b0, us_q} + {1'b0, ul_q}) == {1'b0, e_st};

	assign pool_v  = CW'(cfg_data);
	assign units_v = (pool_v > AMASK) ? AMASK : pool_v;

	assign umatch = urd_q[UDW-1:2*AW] == owner_q;
	assign ulast  = CNW'(uidx_s1) == ucnt_q - CNW'(1);
	assign uaddr  = sh_run_q ? sa_q : ua_q;

	always_comb begin
		fw_en = 1'b0;
		fw_addr = pk_idx_q;
		fw_data = {pk_st_q + sz_a, pk_len_q - sz_a};
		if (cmd.acommit) begin
			fw_en = pk_len_q > sz_a;
		end else if (cmd.fcommit) begin
			fw_en = 1'b1;
			if (lf_q) begin
				fw_addr = l_idx_q;
				fw_data = {l_st_q, l_len_q + ul_q + (rf_q ? r_len_q : '0)};
			end else if (rf_q) begin
				fw_addr = r_idx_q;
				fw_data = {us_q, r_len_q + ul_q};
			end else begin
				fw_addr = s_idx_q;
				fw_data = {us_q, ul_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		frd_q <= fmem[fa_q];
		urd_q <= umem[uaddr];
		if (fw_en) begin
			fmem[fw_addr] <= fw_data;
		end
		if (shv_s1) begin
			umem[swa_s1] <= urd_q;
		end else if (cmd.acommit) begin
			umem[UIW'(ucnt_q)] <= {owner_q, pk_st_q, sz_a};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= FIT_FIRST;
			units_q <= AW'(POOL_INIT);
			nf_q <= '0;
			fvld_q <= NF'(1);
			e0_ovr_q <= 1'b1;
			ucnt_q <= '0;
			f_run_q <= 1'b0;
			fa_q <= '0;
			fv_s1 <= 1'b0;
			fidx_s1 <= '0;
			fov_s1 <= 1'b0;
			fdone_q <= 1'b0;
			u_run_q <= 1'b0;
			u_act_q <= 1'b0;
			ua_q <= '0;
			uv_s1 <= 1'b0;
			uidx_s1 <= '0;
			udone_q <= 1'b0;
			sh_run_q <= 1'b0;
			sa_q <= '0;
			shv_s1 <= 1'b0;
			swa_s1 <= '0;
			shdone_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fdone_q <= 1'b0;
			udone_q <= 1'b0;
			shdone_q <= 1'b0;

			if (cfg_wr_en) begin
				if (cfg_index == REG_FIT) begin
					fit_q <= fit_t'(cfg_data[1:0]);
				end else begin
					units_q <= AW'(units_v);
					fvld_q <= NF'(units_v != '0);
					e0_ovr_q <= 1'b1;
					ucnt_q <= '0;
					nf_q <= '0;
				end
			end

			// free table read pipeline
			fv_s1 <= f_run_q;
			fidx_s1 <= fa_q;
			fov_s1 <= e0_ovr_q && (fa_q == '0);
			if (f_run_q) begin
				if (fa_q == FIW'(NF - 1)) begin
					f_run_q <= 1'b0;
				end else begin
					fa_q <= fa_q + FIW'(1);
				end
			end
			if (fv_s1 && fidx_s1 == FIW'(NF - 1)) begin
				fdone_q <= 1'b1;
			end
			if (cmd.fscan_pick || cmd.nf_retry || cmd.fscan_nbr) begin
				f_run_q <= 1'b1;
				fa_q <= '0;
			end
			if (cmd.nf_retry && (|fvld_q)) begin
				nf_q <= '0;
			end

			// used table read pipeline
			uv_s1 <= u_run_q;
			uidx_s1 <= ua_q;
			if (u_run_q) begin
				if (CNW'(ua_q) == ucnt_q - CNW'(1)) begin
					u_run_q <= 1'b0;
				end else begin
					ua_q <= ua_q + UIW'(1);
				end
			end
			if (u_act_q && uv_s1 && (umatch || ulast)) begin
				u_act_q <= 1'b0;
				u_run_q <= 1'b0;
				udone_q <= 1'b1;
			end
			if (cmd.uscan) begin
				u_run_q <= 1'b1;
				u_act_q <= 1'b1;
				ua_q <= '0;
			end

			// compaction of the used table
			shv_s1 <= sh_run_q;
			swa_s1 <= sa_q - UIW'(1);
			if (sh_run_q) begin
				if (CNW'(sa_q) == ucnt_q - CNW'(1)) begin
					sh_run_q <= 1'b0;
				end else begin
					sa_q <= sa_q + UIW'(1);
				end
			end
			if (shv_s1 && !sh_run_q) begin
				shdone_q <= 1'b1;
				ucnt_q <= ucnt_q - CNW'(1);
			end

			if (cmd.acommit) begin
				if (!(pk_len_q > sz_a)) begin
					fvld_q[pk_idx_q] <= 1'b0;
				end
				ucnt_q <= ucnt_q + CNW'(1);
				if (fit_q == FIT_NEXT) begin
					nf_q <= pk_st_q + sz_a;
				end
			end
			if (cmd.fcommit) begin
				if (lf_q && rf_q) begin
					fvld_q[r_idx_q] <= 1'b0;
				end else if (!lf_q && !rf_q) begin
					fvld_q[s_idx_q] <= 1'b1;
				end
				if (CNW'(u_idx_q) + CNW'(1) < ucnt_q) begin
					sh_run_q <= 1'b1;
					sa_q <= u_idx_q + UIW'(1);
				end else begin
					shdone_q <= 1'b1;
					ucnt_q <= ucnt_q - CNW'(1);
				end
			end
			if (fw_en && fw_addr == '0) begin
				e0_ovr_q <= 1'b0;
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			owner_q <= owner_id;
			size_q <= request_size;
		end
		if (cmd.fscan_pick || cmd.nf_retry || cmd.fscan_nbr) begin
			pk_found_q <= 1'b0;
			lf_q <= 1'b0;
			rf_q <= 1'b0;
			sf_q <= 1'b0;
			nbr_q <= cmd.fscan_nbr;
			rule_q <= (fit_q == FIT_NEXT) ? FIT_FIRST : fit_q;
			low_q <= (cmd.fscan_pick && fit_q == FIT_NEXT) ? nf_q : '0;
		end else if (fv_s1) begin
			if (!nbr_q) begin
				if (cand && (!pk_found_q || better)) begin
					pk_found_q <= 1'b1;
					pk_idx_q <= fidx_s1;
					pk_st_q <= e_st;
					pk_len_q <= e_len;
				end
			end else if (!e_vld) begin
				if (!sf_q) begin
					sf_q <= 1'b1;
					s_idx_q <= fidx_s1;
				end
			end else if (end_lo) begin
				lf_q <= 1'b1;
				l_idx_q <= fidx_s1;
				l_st_q <= e_st;
				l_len_q <= e_len;
			end else if (end_hi) begin
				rf_q <= 1'b1;
				r_idx_q <= fidx_s1;
				r_len_q <= e_len;
			end
		end
		if (cmd.uscan) begin
			ufound_q <= 1'b0;
		end else if (u_act_q && uv_s1 && umatch) begin
			ufound_q <= 1'b1;
			u_idx_q <= uidx_s1;
			us_q <= urd_q[2*AW-1:AW];
			ul_q <= urd_q[AW-1:0];
		end
		if (cmd.fail) begin
			res_st_q <= cmd.fail_code;
			res_start_q <= '0;
			res_len_q <= '0;
		end else if (cmd.acommit) begin
			res_st_q <= ST_OK;
			res_start_q <= SIZE_W'(pk_st_q);
			res_len_q <= size_q;
		end else if (cmd.fcommit) begin
			res_st_q <= ST_OK;
			res_start_q <= SIZE_W'(us_q);
			res_len_q <= SIZE_W'(ul_q);
		end
		if (cmd.out_load) begin
			out_st_q <= res_st_q;
			out_start_q <= res_start_q;
			out_len_q <= res_len_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_st_q;
	assign block_start = out_start_q;
	assign block_length = out_len_q;

	always_comb begin
		st.op_free = op_q == OP_FREE;
		st.size_zero = size_q == '0;
		st.tbl_full = ucnt_q == CNW'(NA);
		st.ucnt_zero = ucnt_q == '0;
		st.nf_mode = fit_q == FIT_NEXT;
		st.fdone = fdone_q;
		st.pk_found = pk_found_q;
		st.udone = udone_q;
		st.ufound = ufound_q;
		st.merge_ok = lf_q || rf_q || sf_q;
		st.shdone = shdone_q;
		st.out_busy = out_valid_q;
	end

endmodule

@@ design/variable_partition_allocator.sv @@
// Variable partition allocator: first, best, worst or next fit over a pool
// of pool_size units, with a free-block table and an allocation table.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index
// (0 fit_method, 1 pool_size); a pool_size write re-forms one free block.
// Requests enter on in_valid/in_ready (op, owner_id, request_size), one at a
// time; each yields one result on out_valid/out_ready (status, block_start,
// block_length).
// An allocate runs one pass over the free table, one table entry a cycle
// through its memory read port, and a second pass when next fit wraps
// around. A free scans the allocation table for the owner, the free table
// for neighbors, then compacts the allocation table one entry a cycle.
// The result sits in an output register; a new request is taken while it
// waits, but that request's result holds in the block until the register is
// taken by the receiver.
// Reset gives first fit, a 640-unit pool as one free block and an empty
// allocation table; no clearing pass is needed.
module variable_partition_allocator #(
	parameter int MAX_FREE_BLOCKS = 64,
	parameter int MAX_ALLOCATIONS = 64,
	parameter int ADDR_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_index,
	input  logic [vpa_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [vpa_pkg::OWNER_W-1:0] owner_id,
	input  logic [vpa_pkg::SIZE_W-1:0]  request_size,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [vpa_pkg::SIZE_W-1:0]  block_start,
	output logic [vpa_pkg::SIZE_W-1:0]  block_length
);
	import vpa_pkg::*;

	cmd_t  cmd;
	stat_t st;

	vpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	vpa_dpath #(
		.NF (MAX_FREE_BLOCKS),
		.NA (MAX_ALLOCATIONS),
		.AW (ADDR_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.owner_id     (owner_id),
		.request_size (request_size),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.block_start  (block_start),
		.block_length (block_length),
		.cmd          (cmd),
		.st           (st)
	);

`include "assert_macros.svh"

	`VPA_ASSERT(a_one_request, (in_valid && in_ready) |=> !in_ready, "request taken while busy")
	`VPA_NEVER(a_cmd_excl, !$onehot0({cmd.acommit, cmd.fcommit, cmd.fail}), "commit clash")
	`VPA_ASSERT(a_out_slot, cmd.out_load |-> (!out_valid || out_ready), "result overwritten")

endmodule
